// ===== design/look_at_view_matrix_defines.svh =====
// Assertion helpers shared by the look-at view matrix design.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define LAVM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define LAVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lavm_pkg.sv =====
package lavm_pkg;

    // Number format of all ports.
    localparam int FRAC_BITS = 16;

    // Normaliser widths.
    localparam int NW      = 64;              // signed input component width
    localparam int MW      = 30;              // scaled magnitude width
    localparam int SQ_BITS = MW + 1;          // square root result width
    localparam int RADW    = 2 * SQ_BITS;     // radicand width
    localparam int RW      = SQ_BITS + 4;     // square root remainder width
    localparam int QW      = FRAC_BITS + 1;   // quotient width
    localparam int NUMW    = MW + FRAC_BITS + 1;

    typedef logic signed [31:0]   word_t;
    typedef logic signed [NW-1:0] nvec_t;

    // Values that travel alongside a vector through a normaliser.
    typedef struct packed {
        word_t [2:0] eye;
        word_t [2:0] up;
        word_t [2:0] fw;
    } side_t;

    localparam word_t AXIS_ONE = word_t'(1 << FRAC_BITS);

    // Round from 2*FRAC_BITS to FRAC_BITS fraction bits, half away from zero.
    function automatic word_t round_half(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[63] ? word_t'(-r[31:0]) : word_t'(r[31:0]);
    endfunction

    // Round as above, negate and saturate to the 32-bit range.
    function automatic word_t neg_round_sat(input logic signed [63:0] x);
        logic [63:0]        m;
        logic [63:0]        r;
        logic signed [63:0] t;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        t = x[63] ? $signed(r) : -$signed(r);
        if (t > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (t < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

endpackage

// ===== design/look_at_view_matrix.sv =====
// Look-at view matrix, fully pipelined: one request accepted per clock and one
// result per cycle while the output is not stalled. Each of the two normalisers
// holds a 31-stage square root and a 17-stage divider. A stalled output holds the
// whole pipeline. Reset (aresetn low, synchronous) clears all valid bits only.
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_side_x,
    output logic signed [31:0] m_side_y,
    output logic signed [31:0] m_side_z,
    output logic signed [31:0] m_side_shift,
    output logic signed [31:0] m_upward_x,
    output logic signed [31:0] m_upward_y,
    output logic signed [31:0] m_upward_z,
    output logic signed [31:0] m_upward_shift,
    output logic signed [31:0] m_back_x,
    output logic signed [31:0] m_back_y,
    output logic signed [31:0] m_back_z,
    output logic signed [31:0] m_back_shift
);
    import lavm_pkg::*;

    logic m_valid_reg;
    logic adv;

    // The pipeline moves whenever the output register is empty or being read.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage A: input register.
    logic        va_reg;
    word_t [2:0] eye_a_reg, tgt_a_reg, up_a_reg;
    nvec_t [2:0] d_a;
    side_t       side_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eye_a_reg <= {s_eye_z, s_eye_y, s_eye_x};
            tgt_a_reg <= {s_target_z, s_target_y, s_target_x};
            up_a_reg  <= {s_up_z, s_up_y, s_up_x};
        end
    end

    // Eye minus target, formed exactly.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_a[i] = nvec_t'($signed(eye_a_reg[i])) - nvec_t'($signed(tgt_a_reg[i]));
        end
        side_a.eye = eye_a_reg;
        side_a.up  = up_a_reg;
        side_a.fw  = '0;
    end

    // Back axis normaliser.
    logic        v_n1;
    word_t [2:0] f_n1;
    side_t       side_n1;

    lavm_norm u_norm_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (va_reg),
        .in_vec    (d_a),
        .in_side   (side_a),
        .out_valid (v_n1),
        .out_vec   (f_n1),
        .out_side  (side_n1)
    );

    // Stage B: products for up x f.
    logic               vb_reg;
    logic signed [63:0] pb_reg [6];
    word_t [2:0]        fb_reg, eye_b_reg, up_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= v_n1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pb_reg[0] <= $signed(side_n1.up[1]) * $signed(f_n1[2]);
            pb_reg[1] <= $signed(side_n1.up[2]) * $signed(f_n1[1]);
            pb_reg[2] <= $signed(side_n1.up[2]) * $signed(f_n1[0]);
            pb_reg[3] <= $signed(side_n1.up[0]) * $signed(f_n1[2]);
            pb_reg[4] <= $signed(side_n1.up[0]) * $signed(f_n1[1]);
            pb_reg[5] <= $signed(side_n1.up[1]) * $signed(f_n1[0]);
            fb_reg    <= f_n1;
            eye_b_reg <= side_n1.eye;
            up_b_reg  <= side_n1.up;
        end
    end

    // Stage C: cross product differences.
    logic        vc_reg;
    nvec_t [2:0] c_c_reg;
    side_t       side_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (adv) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_c_reg[0]     <= pb_reg[0] - pb_reg[1];
            c_c_reg[1]     <= pb_reg[2] - pb_reg[3];
            c_c_reg[2]     <= pb_reg[4] - pb_reg[5];
            side_c_reg.eye <= eye_b_reg;
            side_c_reg.up  <= up_b_reg;
            side_c_reg.fw  <= fb_reg;
        end
    end

    // Side axis normaliser.
    logic        v_n2;
    word_t [2:0] s_n2;
    side_t       side_n2;

    lavm_norm u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vc_reg),
        .in_vec    (c_c_reg),
        .in_side   (side_c_reg),
        .out_valid (v_n2),
        .out_vec   (s_n2),
        .out_side  (side_n2)
    );

    // Stage D: products for f x s and the dot products of s and f with eye.
    logic               vd_reg;
    logic signed [63:0] fs_d_reg [6];
    logic signed [63:0] se_d_reg [3];
    logic signed [63:0] fe_d_reg [3];
    word_t [2:0]        s_d_reg, f_d_reg, eye_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (adv) begin
            vd_reg <= v_n2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fs_d_reg[0] <= $signed(side_n2.fw[1]) * $signed(s_n2[2]);
            fs_d_reg[1] <= $signed(side_n2.fw[2]) * $signed(s_n2[1]);
            fs_d_reg[2] <= $signed(side_n2.fw[2]) * $signed(s_n2[0]);
            fs_d_reg[3] <= $signed(side_n2.fw[0]) * $signed(s_n2[2]);
            fs_d_reg[4] <= $signed(side_n2.fw[0]) * $signed(s_n2[1]);
            fs_d_reg[5] <= $signed(side_n2.fw[1]) * $signed(s_n2[0]);
            for (int i = 0; i < 3; i++) begin
                se_d_reg[i] <= $signed(s_n2[i]) * $signed(side_n2.eye[i]);
                fe_d_reg[i] <= $signed(side_n2.fw[i]) * $signed(side_n2.eye[i]);
            end
            s_d_reg   <= s_n2;
            f_d_reg   <= side_n2.fw;
            eye_d_reg <= side_n2.eye;
        end
    end

    // Stage E: rounded upward axis, and the side and back dot product sums.
    logic               ve_reg;
    word_t [2:0]        u_e_reg, s_e_reg, f_e_reg, eye_e_reg;
    logic signed [63:0] ssum_e_reg, fsum_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (adv) begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_e_reg[0] <= round_half(fs_d_reg[0] - fs_d_reg[1]);
            u_e_reg[1] <= round_half(fs_d_reg[2] - fs_d_reg[3]);
            u_e_reg[2] <= round_half(fs_d_reg[4] - fs_d_reg[5]);
            ssum_e_reg <= se_d_reg[0] + se_d_reg[1] + se_d_reg[2];
            fsum_e_reg <= fe_d_reg[0] + fe_d_reg[1] + fe_d_reg[2];
            s_e_reg    <= s_d_reg;
            f_e_reg    <= f_d_reg;
            eye_e_reg  <= eye_d_reg;
        end
    end

    // Stage F: upward dot eye products; side and back translations.
    logic               vf_reg;
    logic signed [63:0] ue_f_reg [3];
    word_t [2:0]        u_f_reg, s_f_reg, f_f_reg;
    word_t              ssh_f_reg, fsh_f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (adv) begin
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                ue_f_reg[i] <= $signed(u_e_reg[i]) * $signed(eye_e_reg[i]);
            end
            ssh_f_reg <= neg_round_sat(ssum_e_reg);
            fsh_f_reg <= neg_round_sat(fsum_e_reg);
            u_f_reg   <= u_e_reg;
            s_f_reg   <= s_e_reg;
            f_f_reg   <= f_e_reg;
        end
    end

    // Stage G: upward dot product sum.
    logic               vg_reg;
    logic signed [63:0] usum_g_reg;
    word_t [2:0]        u_g_reg, s_g_reg, f_g_reg;
    word_t              ssh_g_reg, fsh_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (adv) begin
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            usum_g_reg <= ue_f_reg[0] + ue_f_reg[1] + ue_f_reg[2];
            u_g_reg    <= u_f_reg;
            s_g_reg    <= s_f_reg;
            f_g_reg    <= f_f_reg;
            ssh_g_reg  <= ssh_f_reg;
            fsh_g_reg  <= fsh_f_reg;
        end
    end

    // Output register: upward translation and the finished rows.
    word_t [2:0] s_o_reg, u_o_reg, f_o_reg;
    word_t       ssh_o_reg, ush_o_reg, fsh_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_o_reg   <= s_g_reg;
            u_o_reg   <= u_g_reg;
            f_o_reg   <= f_g_reg;
            ssh_o_reg <= ssh_g_reg;
            ush_o_reg <= neg_round_sat(usum_g_reg);
            fsh_o_reg <= fsh_g_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_side_x       = s_o_reg[0];
    assign m_side_y       = s_o_reg[1];
    assign m_side_z       = s_o_reg[2];
    assign m_side_shift   = ssh_o_reg;
    assign m_upward_x     = u_o_reg[0];
    assign m_upward_y     = u_o_reg[1];
    assign m_upward_z     = u_o_reg[2];
    assign m_upward_shift = ush_o_reg;
    assign m_back_x       = f_o_reg[0];
    assign m_back_y       = f_o_reg[1];
    assign m_back_z       = f_o_reg[2];
    assign m_back_shift   = fsh_o_reg;

    // Checks on the finished result.
    logic back_zero, side_zero, upward_zero, back_in_range;

    assign back_zero     = (m_back_x == '0) && (m_back_y == '0) && (m_back_z == '0);
    assign side_zero     = (m_side_x == '0) && (m_side_y == '0) && (m_side_z == '0);
    assign upward_zero   = (m_upward_x == '0) && (m_upward_y == '0) && (m_upward_z == '0);
    assign back_in_range = (m_back_x <= AXIS_ONE) && (m_back_x >= -AXIS_ONE);

    `LAVM_ASSERT_IMPL(a_back_range, m_valid_reg, back_in_range, "back axis exceeds unit length")
    `LAVM_ASSERT_IMPL(a_zero_back, m_valid_reg && back_zero, side_zero && upward_zero && (m_back_shift == '0), "zero back axis with non-zero row")
    `LAVM_ASSERT_IMPL(a_zero_side, m_valid_reg && side_zero, upward_zero && (m_side_shift == '0) && (m_upward_shift == '0), "zero side axis with non-zero row")
    `LAVM_ASSERT_NEXT(a_stall_hold, !adv && vg_reg, vg_reg && $stable(usum_g_reg), "pipeline moved while stalled")

endmodule

// ===== design/lavm_norm.sv =====
module lavm_norm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  lavm_pkg::nvec_t [2:0]          in_vec,
    input  lavm_pkg::side_t                in_side,
    output logic                           out_valid,
    output lavm_pkg::word_t [2:0]          out_vec,
    output lavm_pkg::side_t                out_side
);
    import lavm_pkg::*;

    localparam int PW  = $clog2(NW);
    localparam int SQW = 2 * MW;

    typedef struct packed {
        logic [2:0][MW-1:0] mg;
        logic [2:0]         ng;
        logic               zr;
        side_t              sd;
    } car_t;

    // Stage 1: sign and magnitude of each component.
    logic                v1_reg;
    logic [NW-1:0]       mg1_reg [3];
    logic [2:0]          ng1_reg;
    side_t               sd1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ng1_reg[i] <= in_vec[i][NW-1];
                mg1_reg[i] <= in_vec[i][NW-1] ? NW'(-in_vec[i]) : NW'(in_vec[i]);
            end
            sd1_reg <= in_side;
        end
    end

    // Stage 2: largest magnitude.
    logic                v2_reg;
    logic [NW-1:0]       m2_next, m2_reg;
    logic [NW-1:0]       mg2_reg [3];
    logic [2:0]          ng2_reg;
    side_t               sd2_reg;

    always_comb begin
        m2_next = mg1_reg[0];
        if (mg1_reg[1] > m2_next) begin
            m2_next = mg1_reg[1];
        end
        if (mg1_reg[2] > m2_next) begin
            m2_next = mg1_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg  <= m2_next;
            mg2_reg <= mg1_reg;
            ng2_reg <= ng1_reg;
            sd2_reg <= sd1_reg;
        end
    end

    // Stage 3: position of the leading one of the largest magnitude.
    logic                v3_reg;
    logic [PW-1:0]       p3_next, p3_reg;
    logic                z3_reg;
    logic [NW-1:0]       mg3_reg [3];
    logic [2:0]          ng3_reg;
    side_t               sd3_reg;

    always_comb begin
        p3_next = '0;
        for (int b = 0; b < NW; b++) begin
            if (m2_reg[b]) begin
                p3_next = PW'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg  <= p3_next;
            z3_reg  <= (m2_reg == '0);
            mg3_reg <= mg2_reg;
            ng3_reg <= ng2_reg;
            sd3_reg <= sd2_reg;
        end
    end

    // Stage 4: scale all magnitudes so that the largest lies in [2^29, 2^30).
    logic                v4_reg;
    logic [NW-1:0]       wide4 [3];
    car_t                c4_next, c4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (p3_reg >= PW'(MW)) begin
                wide4[i] = mg3_reg[i] >> (p3_reg - PW'(MW - 1));
            end else begin
                wide4[i] = mg3_reg[i] << (PW'(MW - 1) - p3_reg);
            end
            c4_next.mg[i] = wide4[i][MW-1:0];
        end
        c4_next.ng = ng3_reg;
        c4_next.zr = z3_reg;
        c4_next.sd = sd3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c4_reg <= c4_next;
        end
    end

    // Stage 5: squares.
    logic                v5_reg;
    logic [SQW-1:0]      sq5_reg [3];
    car_t                c5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= SQW'(c4_reg.mg[i]) * SQW'(c4_reg.mg[i]);
            end
            c5_reg <= c4_reg;
        end
    end

    // Square root, one result bit per stage; entry 0 holds the sum of squares.
    logic                sv_reg   [0:SQ_BITS];
    logic [RADW-1:0]     rad_reg  [0:SQ_BITS];
    logic [RW-1:0]       rem_reg  [0:SQ_BITS];
    logic [SQ_BITS-1:0]  root_reg [0:SQ_BITS];
    car_t                sc_reg   [0:SQ_BITS];
    logic [RW-1:0]       st_val   [SQ_BITS];
    logic [RW-1:0]       st_trial [SQ_BITS];

    always_comb begin
        for (int j = 0; j < SQ_BITS; j++) begin
            st_val[j]   = {rem_reg[j][RW-3:0], rad_reg[j][RADW-1 -: 2]};
            st_trial[j] = {2'b00, root_reg[j], 2'b01};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= SQ_BITS; j++) begin
                sv_reg[j] <= 1'b0;
            end
        end else if (en) begin
            sv_reg[0] <= v5_reg;
            for (int j = 0; j < SQ_BITS; j++) begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= RADW'(sq5_reg[0]) + RADW'(sq5_reg[1]) + RADW'(sq5_reg[2]);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sc_reg[0]   <= c5_reg;
            for (int j = 0; j < SQ_BITS; j++) begin
                rad_reg[j+1] <= rad_reg[j] << 2;
                sc_reg[j+1]  <= sc_reg[j];
                if (st_val[j] >= st_trial[j]) begin
                    rem_reg[j+1]  <= st_val[j] - st_trial[j];
                    root_reg[j+1] <= {root_reg[j][SQ_BITS-2:0], 1'b1};
                end else begin
                    rem_reg[j+1]  <= st_val[j];
                    root_reg[j+1] <= {root_reg[j][SQ_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Rounded division by the length, one quotient bit per stage, MSB first.
    logic                dv_reg   [0:QW];
    logic [NUMW-1:0]     drem_reg [0:QW][3];
    logic [QW-1:0]       dq_reg   [0:QW][3];
    logic [SQ_BITS-1:0]  dl_reg   [0:QW];
    car_t                dc_reg   [0:QW];
    logic [NUMW-1:0]     dsub     [QW];
    logic                dge      [QW][3];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            dsub[k] = NUMW'(dl_reg[k]) << (QW - 1 - k);
            for (int i = 0; i < 3; i++) begin
                dge[k][i] = (drem_reg[k][i] >= dsub[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= sv_reg[SQ_BITS];
            for (int k = 0; k < QW; k++) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= root_reg[SQ_BITS];
            dc_reg[0] <= sc_reg[SQ_BITS];
            for (int i = 0; i < 3; i++) begin
                drem_reg[0][i] <= (NUMW'(sc_reg[SQ_BITS].mg[i]) << FRAC_BITS)
                                  + NUMW'(root_reg[SQ_BITS] >> 1);
                dq_reg[0][i]   <= '0;
            end
            for (int k = 0; k < QW; k++) begin
                dl_reg[k+1] <= dl_reg[k];
                dc_reg[k+1] <= dc_reg[k];
                for (int i = 0; i < 3; i++) begin
                    drem_reg[k+1][i] <= dge[k][i] ? drem_reg[k][i] - dsub[k]
                                                   : drem_reg[k][i];
                    dq_reg[k+1][i]   <= {dq_reg[k][i][QW-2:0], dge[k][i]};
                end
            end
        end
    end

    // Output stage: apply signs, and force zero for a zero-length vector.
    logic                ov_reg;
    word_t [2:0]         ovec_reg;
    side_t               oside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dc_reg[QW].zr) begin
                    ovec_reg[i] <= '0;
                end else if (dc_reg[QW].ng[i]) begin
                    ovec_reg[i] <= -word_t'(32'(dq_reg[QW][i]));
                end else begin
                    ovec_reg[i] <= word_t'(32'(dq_reg[QW][i]));
                end
            end
            oside_reg <= dc_reg[QW].sd;
        end
    end

    assign out_valid = ov_reg;
    assign out_vec   = ovec_reg;
    assign out_side  = oside_reg;

endmodule
